// ===== hdl/rpe_pkg.sv =====
// Shared constants for the rotary position embedding block.
// No dependencies; every other file imports this package.
package rpe_pkg;

    localparam int POS_W    = 12;
    localparam int PAIR_W   = 5;
    localparam int DATA_W   = 16;
    localparam int FREQ_W   = 32;
    localparam int ANGLE_W  = 32;

    // CORDIC datapath: x/y in Q30 with headroom, z in units of 2^-24 turn
    localparam int XY_W          = 33;
    localparam int Z_W           = 25;
    localparam int CORDIC_STAGES = 20;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [Z_W-1:0] CORDIC_ATAN [CORDIC_STAGES] = '{
        25'd2097152, 25'd1238021, 25'd654136, 25'd332050, 25'd166669,
        25'd83416,   25'd41718,   25'd20860,  25'd10430,  25'd5215,
        25'd2608,    25'd1304,    25'd652,    25'd326,    25'd163,
        25'd81,      25'd41,      25'd20,     25'd10,     25'd5
    };

    // Frequency table generation constants
    localparam logic [63:0] LOG2_THETA_Q32 = 64'd81310467867;
    localparam logic [63:0] LN2_Q31        = 64'd1488522236;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

    // Output rounding: Q42 products back to Q3.12
    localparam int PROD_W     = DATA_W + XY_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 30;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd536870912);
    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sh8000;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

endpackage

// ===== hdl/rpe_if.sv =====
// Stream interfaces for the rotary position embedding block.
// Depends on rpe_pkg for field widths.
interface rpe_in_if;
    import rpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         position;
    logic [PAIR_W-1:0]        pair_index;
    logic signed [DATA_W-1:0] x_first;
    logic signed [DATA_W-1:0] x_second;

    modport source (output valid, position, pair_index, x_first, x_second, input ready);
    modport sink   (input valid, position, pair_index, x_first, x_second, output ready);
endinterface

interface rpe_out_if;
    import rpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] y_first;
    logic signed [DATA_W-1:0] y_second;

    modport source (output valid, y_first, y_second, input ready);
    modport sink   (input valid, y_first, y_second, output ready);
endinterface

// ===== hdl/rpe_angle.sv =====
// Angle front end: frequency table lookup and position multiply, two stages.
// Depends on rpe_pkg; the table is built at elaboration from HEAD_SIZE.
module rpe_angle #(
    parameter int HEAD_SIZE = 64,
    parameter int MAX_POS   = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [rpe_pkg::POS_W-1:0]         position,
    input  logic [rpe_pkg::PAIR_W-1:0]        pair_index,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_second,
    output logic                              out_valid,
    output logic [rpe_pkg::ANGLE_W-1:0]       angle,
    output logic signed [rpe_pkg::DATA_W-1:0] out_x_first,
    output logic signed [rpe_pkg::DATA_W-1:0] out_x_second
);
    import rpe_pkg::*;

    localparam int HALF  = HEAD_SIZE / 2;
    localparam int IDX_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int J_W   = 8;
    localparam int PE_W  = 17;
    localparam int MUL_W = POS_W + FREQ_W;

    typedef logic [FREQ_W-1:0] freq_table_t [HALF];

    // Per-pair frequency in Q0.32 turns, via a fixed-point exp series
    function automatic logic [FREQ_W-1:0] freq_entry(input int unsigned j);
        logic [63:0] e;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] prod;
        logic [5:0]  s;
        e    = (64'(j) * 64'd2 * LOG2_THETA_Q32) / 64'(HEAD_SIZE);
        u    = {32'b0, e[31:0]};
        v    = (u * LN2_Q31) >> 32;
        sum  = 64'd1 << 31;
        term = 64'd1 << 31;
        for (int k = 1; k <= 13; k++) begin
            term = (term * v) >> 31;
            case (k)
                2:       term = term / 2;
                3:       term = term / 3;
                4:       term = term / 4;
                5:       term = term / 5;
                6:       term = term / 6;
                7:       term = term / 7;
                8:       term = term / 8;
                9:       term = term / 9;
                10:      term = term / 10;
                11:      term = term / 11;
                12:      term = term / 12;
                13:      term = term / 13;
                default: term = term;
            endcase
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        s    = 6'd31 + 6'(e[36:32]);
        prod = sum * INV_TWO_PI_Q32 + (64'd1 << (s - 6'd1));
        return FREQ_W'(prod >> s);
    endfunction

    function automatic freq_table_t build_freq_table();
        freq_table_t tab;
        for (int j = 0; j < HALF; j++)
            tab[j] = freq_entry(unsigned'(j));
        return tab;
    endfunction

    localparam freq_table_t FREQ_TABLE = build_freq_table();

    logic [J_W-1:0]           j_clamped;
    logic [POS_W-1:0]         pos_clamped;
    logic [MUL_W-1:0]         product;

    logic                     lookup_valid_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic signed [DATA_W-1:0] x1_a_reg;
    logic signed [DATA_W-1:0] x2_a_reg;

    logic                     angle_valid_reg;
    logic [ANGLE_W-1:0]       angle_reg;
    logic signed [DATA_W-1:0] x1_b_reg;
    logic signed [DATA_W-1:0] x2_b_reg;

    always_comb
    begin
        j_clamped = J_W'(pair_index);
        if (j_clamped >= J_W'(HALF))
            j_clamped = J_W'(HALF - 1);
        pos_clamped = position;
        if (PE_W'(position) >= PE_W'(MAX_POS))
            pos_clamped = POS_W'(MAX_POS - 1);
    end

    assign product = MUL_W'(pos_reg) * MUL_W'(freq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_valid_reg <= 1'b0;
            angle_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            lookup_valid_reg <= in_valid;
            angle_valid_reg  <= lookup_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_reg   <= pos_clamped;
            freq_reg  <= FREQ_TABLE[j_clamped[IDX_W-1:0]];
            x1_a_reg  <= x_first;
            x2_a_reg  <= x_second;
            // keep the angle mod one turn
            angle_reg <= product[ANGLE_W-1:0];
            x1_b_reg  <= x1_a_reg;
            x2_b_reg  <= x2_a_reg;
        end
    end

    assign out_valid    = angle_valid_reg;
    assign angle        = angle_reg;
    assign out_x_first  = x1_b_reg;
    assign out_x_second = x2_b_reg;

endmodule

// ===== hdl/rpe_cordic.sv =====
// Unrolled rotation-mode CORDIC, one iteration per register stage.
// Depends on rpe_pkg for widths, gain and arctangent constants.
module rpe_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [rpe_pkg::ANGLE_W-1:0]       angle,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_second,
    output logic                              out_valid,
    output logic [1:0]                        quad,
    output logic signed [rpe_pkg::XY_W-1:0]   cos_val,
    output logic signed [rpe_pkg::XY_W-1:0]   sin_val,
    output logic signed [rpe_pkg::DATA_W-1:0] out_x_first,
    output logic signed [rpe_pkg::DATA_W-1:0] out_x_second
);
    import rpe_pkg::*;

    logic                     valid_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]   x_reg     [CORDIC_STAGES];
    logic signed [XY_W-1:0]   y_reg     [CORDIC_STAGES];
    logic signed [Z_W-1:0]    z_reg     [CORDIC_STAGES];
    logic [1:0]               quad_reg  [CORDIC_STAGES];
    logic signed [DATA_W-1:0] x1_reg    [CORDIC_STAGES];
    logic signed [DATA_W-1:0] x2_reg    [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic                     valid_prev;
        logic signed [XY_W-1:0]   x_prev;
        logic signed [XY_W-1:0]   y_prev;
        logic signed [Z_W-1:0]    z_prev;
        logic [1:0]               quad_prev;
        logic signed [DATA_W-1:0] x1_prev;
        logic signed [DATA_W-1:0] x2_prev;
        logic signed [XY_W-1:0]   x_next;
        logic signed [XY_W-1:0]   y_next;
        logic signed [Z_W-1:0]    z_next;

        if (i == 0)
        begin : g_first
            // residual angle below a quarter turn, in 2^-24 turn units
            assign valid_prev = in_valid;
            assign x_prev     = CORDIC_GAIN;
            assign y_prev     = '0;
            assign z_prev     = $signed({3'b0, angle[ANGLE_W-3:8]});
            assign quad_prev  = angle[ANGLE_W-1:ANGLE_W-2];
            assign x1_prev    = x_first;
            assign x2_prev    = x_second;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[i-1];
            assign x_prev     = x_reg[i-1];
            assign y_prev     = y_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign quad_prev  = quad_reg[i-1];
            assign x1_prev    = x1_reg[i-1];
            assign x2_prev    = x2_reg[i-1];
        end

        always_comb
        begin
            if (!z_prev[Z_W-1])
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - $signed(CORDIC_ATAN[i]);
            end
            else
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + $signed(CORDIC_ATAN[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (advance)
                valid_reg[i] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                quad_reg[i] <= quad_prev;
                x1_reg[i]   <= x1_prev;
                x2_reg[i]   <= x2_prev;
            end
        end
    end

    assign out_valid    = valid_reg[CORDIC_STAGES-1];
    assign quad         = quad_reg[CORDIC_STAGES-1];
    assign cos_val      = x_reg[CORDIC_STAGES-1];
    assign sin_val      = y_reg[CORDIC_STAGES-1];
    assign out_x_first  = x1_reg[CORDIC_STAGES-1];
    assign out_x_second = x2_reg[CORDIC_STAGES-1];

endmodule

// ===== hdl/rpe_rotate.sv =====
// Quadrant mapping, pair rotation multiplies, rounding and saturation.
// Depends on rpe_pkg; two register stages.
module rpe_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [1:0]                        quad,
    input  logic signed [rpe_pkg::XY_W-1:0]   cos_val,
    input  logic signed [rpe_pkg::XY_W-1:0]   sin_val,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] x_second,
    output logic                              out_valid,
    output logic signed [rpe_pkg::DATA_W-1:0] y_first,
    output logic signed [rpe_pkg::DATA_W-1:0] y_second
);
    import rpe_pkg::*;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = (v + ROUND_HALF) >>> FRAC_SHIFT;
        if (r > ACC_W'(SAT_MAX))
            return SAT_MAX;
        if (r < ACC_W'(SAT_MIN))
            return SAT_MIN;
        return r[DATA_W-1:0];
    endfunction

    logic signed [XY_W-1:0]   c_val;
    logic signed [XY_W-1:0]   s_val;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] x1c_reg;
    logic signed [PROD_W-1:0] x2s_reg;
    logic signed [PROD_W-1:0] x2c_reg;
    logic signed [PROD_W-1:0] x1s_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] y1_reg;
    logic signed [DATA_W-1:0] y2_reg;

    always_comb
    begin
        case (quad)
            QUAD_FIRST:
            begin
                c_val = cos_val;
                s_val = sin_val;
            end
            QUAD_SECOND:
            begin
                c_val = -sin_val;
                s_val = cos_val;
            end
            QUAD_THIRD:
            begin
                c_val = -cos_val;
                s_val = -sin_val;
            end
            default:
            begin
                c_val = sin_val;
                s_val = -cos_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1c_reg <= PROD_W'(x_first) * PROD_W'(c_val);
            x2s_reg <= PROD_W'(x_second) * PROD_W'(s_val);
            x2c_reg <= PROD_W'(x_second) * PROD_W'(c_val);
            x1s_reg <= PROD_W'(x_first) * PROD_W'(s_val);
            y1_reg  <= round_sat(ACC_W'(x1c_reg) - ACC_W'(x2s_reg));
            y2_reg  <= round_sat(ACC_W'(x2c_reg) + ACC_W'(x1s_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign y_first   = y1_reg;
    assign y_second  = y2_reg;

endmodule

// ===== hdl/rotary_position_embedding_top.sv =====
// Rotary position embedding: rotates one element pair per item by position * f(pair).
// Pipeline: 2 angle stages, 20 CORDIC stages, then multiply and round stages.
// Throughput one item per cycle; the whole pipeline holds while the output stalls.
// rst_n (asynchronous, active low) clears every stage valid bit; data is not reset.
// Depends on rpe_pkg, rpe_if, rpe_angle, rpe_cordic and rpe_rotate.
module rotary_position_embedding_top #(
    parameter int HEAD_SIZE = 64,
    parameter int MAX_POS   = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    rpe_in_if.sink    operand,
    rpe_out_if.source result
);
    import rpe_pkg::*;

    logic                     advance;

    logic                     angle_valid;
    logic [ANGLE_W-1:0]       angle;
    logic signed [DATA_W-1:0] angle_x1;
    logic signed [DATA_W-1:0] angle_x2;

    logic                     cordic_valid;
    logic [1:0]               cordic_quad;
    logic signed [XY_W-1:0]   cordic_cos;
    logic signed [XY_W-1:0]   cordic_sin;
    logic signed [DATA_W-1:0] cordic_x1;
    logic signed [DATA_W-1:0] cordic_x2;

    // advance all stages unless a finished item waits at the output
    assign advance       = !result.valid || result.ready;
    assign operand.ready = advance;

    rpe_angle #(
        .HEAD_SIZE (HEAD_SIZE),
        .MAX_POS   (MAX_POS)
    ) u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (operand.valid),
        .position     (operand.position),
        .pair_index   (operand.pair_index),
        .x_first      (operand.x_first),
        .x_second     (operand.x_second),
        .out_valid    (angle_valid),
        .angle        (angle),
        .out_x_first  (angle_x1),
        .out_x_second (angle_x2)
    );

    rpe_cordic u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (angle_valid),
        .angle        (angle),
        .x_first      (angle_x1),
        .x_second     (angle_x2),
        .out_valid    (cordic_valid),
        .quad         (cordic_quad),
        .cos_val      (cordic_cos),
        .sin_val      (cordic_sin),
        .out_x_first  (cordic_x1),
        .out_x_second (cordic_x2)
    );

    rpe_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (cordic_valid),
        .quad      (cordic_quad),
        .cos_val   (cordic_cos),
        .sin_val   (cordic_sin),
        .x_first   (cordic_x1),
        .x_second  (cordic_x2),
        .out_valid (result.valid),
        .y_first   (result.y_first),
        .y_second  (result.y_second)
    );

endmodule

// ===== dv/tb.sv =====
// Testbench for rotary_position_embedding_top: drives element pairs and checks
// each rotated pair against a bit-exact predictor. Depends on rpe_pkg, rpe_if
// and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import rpe_pkg::*;

    localparam int HEAD_SIZE     = 64;
    localparam int MAX_POS       = 4096;
    localparam int STUCK_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 300;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_LIMIT  = 20;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_first;
        logic signed [DATA_W-1:0] y_second;
    } rotated_pair_t;

    class rotation_checker;
        rotated_pair_t expected_rotations[$];
        int unsigned   mismatches;
        int unsigned   rotations_checked;
        int unsigned   saturated_outputs;
        int unsigned   quadrant_hits [4];

        // Turn rate of pair j: theta^(-2j/d) / (2*pi) as Q0.32 turns per position
        function automatic logic [63:0] turn_rate(logic [63:0] j);
            logic [63:0] expo;
            logic [63:0] octaves;
            logic [63:0] frac_ln;
            logic [63:0] series;
            logic [63:0] term;
            int unsigned shift;
            expo    = (64'd2 * j * 64'd81310467867) / 64'(HEAD_SIZE);
            octaves = expo >> 32;
            frac_ln = ((expo & 64'hFFFF_FFFF) * 64'd1488522236) >> 32;
            series  = 64'd1 << 31;
            term    = 64'd1 << 31;
            for (int k = 1; k <= 13; k++)
            begin
                term = ((term * frac_ln) >> 31) / 64'(k);
                if (k % 2 == 1)
                    series = series - term;
                else
                    series = series + term;
            end
            shift = 31 + int'(octaves & 64'd31);
            return (series * 64'd683565276 + (64'd1 << (shift - 1))) >> shift;
        endfunction

        function automatic logic signed [DATA_W-1:0] round_to_q12(longint acc);
            longint r;
            r = (acc + (longint'(1) <<< 29)) >>> 30;
            if (r > 32767)
            begin
                r = 32767;
                saturated_outputs++;
            end
            else if (r < -32768)
            begin
                r = -32768;
                saturated_outputs++;
            end
            return DATA_W'(r);
        endfunction

        function automatic rotated_pair_t rotate_pair(logic [POS_W-1:0] position,
                                                      logic [PAIR_W-1:0] pair_index,
                                                      logic signed [DATA_W-1:0] x_first,
                                                      logic signed [DATA_W-1:0] x_second);
            longint atan_step [20] = '{
                2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
            };
            logic [63:0]   pos_c;
            logic [63:0]   pair_c;
            logic [63:0]   angle;
            logic [1:0]    quad;
            longint        cx;
            longint        cy;
            longint        z;
            longint        dx;
            longint        dy;
            longint        c;
            longint        s;
            rotated_pair_t rotated;
            pos_c  = 64'(position);
            pair_c = 64'(pair_index);
            if (pair_c >= 64'(HEAD_SIZE / 2))
                pair_c = 64'(HEAD_SIZE / 2 - 1);
            if (pos_c >= 64'(MAX_POS))
                pos_c = 64'(MAX_POS - 1);
            angle = (pos_c * turn_rate(pair_c)) & 64'hFFFF_FFFF;
            quad  = angle[31:30];
            z     = longint'((angle & 64'h3FFF_FFFF) >> 8);
            cx    = 652032874;
            cy    = 0;
            for (int i = 0; i < 20; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0)
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - atan_step[i];
                end
                else
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + atan_step[i];
                end
            end
            case (quad)
                QUAD_FIRST:  begin c = cx;  s = cy;  end
                QUAD_SECOND: begin c = -cy; s = cx;  end
                QUAD_THIRD:  begin c = -cx; s = -cy; end
                default:     begin c = cy;  s = -cx; end
            endcase
            quadrant_hits[quad]++;
            rotated.y_first  = round_to_q12(longint'(x_first) * c - longint'(x_second) * s);
            rotated.y_second = round_to_q12(longint'(x_second) * c + longint'(x_first) * s);
            return rotated;
        endfunction

        function void note_pair(logic [POS_W-1:0] position, logic [PAIR_W-1:0] pair_index,
                                logic signed [DATA_W-1:0] x_first,
                                logic signed [DATA_W-1:0] x_second);
            expected_rotations.push_back(rotate_pair(position, pair_index, x_first, x_second));
        endfunction

        function void check_rotation(logic signed [DATA_W-1:0] y_first,
                                     logic signed [DATA_W-1:0] y_second);
            rotated_pair_t want;
            rotations_checked++;
            if (expected_rotations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected item y_first=%0d y_second=%0d",
                             $realtime, y_first, y_second);
                return;
            end
            want = expected_rotations.pop_front();
            if (want.y_first !== y_first)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: y_first expected %0d actual %0d",
                             $realtime, want.y_first, y_first);
            end
            if (want.y_second !== y_second)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: y_second expected %0d actual %0d",
                             $realtime, want.y_second, y_second);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rpe_in_if  operand();
    rpe_out_if result();

    rotary_position_embedding_top #(
        .HEAD_SIZE (HEAD_SIZE),
        .MAX_POS   (MAX_POS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result)
    );

    rotation_checker sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned pairs_accepted;
    int unsigned stuck_cycles;
    bit          hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watch both channels; stop the run if neither moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (operand.valid && operand.ready)
            begin
                sb.note_pair(operand.position, operand.pair_index,
                             operand.x_first, operand.x_second);
                pairs_accepted++;
            end
            if (result.valid && result.ready)
                sb.check_rotation(result.y_first, result.y_second);
            if ((operand.valid && operand.ready) || (result.valid && result.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $realtime, STUCK_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off early in the unthrottled phase
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.rotations_checked >= 100)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    result.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pair(logic [POS_W-1:0] position, logic [PAIR_W-1:0] pair_index,
                             logic signed [DATA_W-1:0] x_first,
                             logic signed [DATA_W-1:0] x_second);
        while ($urandom_range(99) < send_idle_pct)
        begin
            operand.valid <= 1'b0;
            @(negedge clk);
        end
        operand.valid      <= 1'b1;
        operand.position   <= position;
        operand.pair_index <= pair_index;
        operand.x_first    <= x_first;
        operand.x_second   <= x_second;
        do
            @(posedge clk);
        while (!operand.ready);
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_element();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? SAT_MAX : SAT_MIN;
            1, 2:    return DATA_W'($signed($urandom_range(512)) - 256);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_random_pairs(int unsigned count);
        logic [POS_W-1:0] position;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(15))
                0:       position = '0;
                1:       position = '1;
                default: position = POS_W'($urandom_range(4095));
            endcase
            send_pair(position, PAIR_W'($urandom_range(31)), pick_element(), pick_element());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        operand.valid      = 1'b0;
        operand.position   = '0;
        operand.pair_index = '0;
        operand.x_first    = '0;
        operand.x_second   = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corners: zero angle, extreme positions and pairs, full-scale elements
        send_pair(POS_W'(0), PAIR_W'(0), 16'sd0, 16'sd0);
        send_pair(POS_W'(0), PAIR_W'(0), SAT_MAX, SAT_MIN);
        send_pair(POS_W'(4095), PAIR_W'(31), SAT_MIN, SAT_MAX);
        send_pair(POS_W'(4095), PAIR_W'(0), SAT_MAX, SAT_MAX);
        send_pair(POS_W'(4095), PAIR_W'(31), SAT_MAX, SAT_MAX);
        send_pair(POS_W'(4095), PAIR_W'(15), SAT_MIN, SAT_MIN);
        // Pair 0 turns about 0.16 turn per position: walk all four quadrants
        for (int p = 1; p <= 8; p++)
            send_pair(POS_W'(p), PAIR_W'(0), 16'sd4096, 16'sd0);
        // Drive the first output past full scale, in both directions
        send_pair(POS_W'(1), PAIR_W'(0), SAT_MAX, SAT_MIN);
        send_pair(POS_W'(1), PAIR_W'(0), SAT_MIN, SAT_MAX);
        send_pair(POS_W'(5), PAIR_W'(0), SAT_MIN, SAT_MIN);
        send_pair(POS_W'(3), PAIR_W'(0), SAT_MAX, SAT_MAX);
        send_pair(POS_W'(2048), PAIR_W'(16), -16'sd1, 16'sd1);
        send_pair(POS_W'(100), PAIR_W'(7), 16'sd12345, -16'sd23456);
        send_pair(POS_W'(1), PAIR_W'(31), 16'sd1, -16'sd1);

        send_random_pairs(PHASE_ITEMS);
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        send_random_pairs(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        send_random_pairs(PHASE_ITEMS);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_random_pairs(PHASE_ITEMS);
        operand.valid <= 1'b0;
        recv_stall_pct = 0;

        while (sb.expected_rotations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Rotated %0d pairs, checked %0d results, %0d saturated outputs.",
                 pairs_accepted, sb.rotations_checked, sb.saturated_outputs);
        $display("Quadrants hit %0d/%0d/%0d/%0d under four throttling mixes and a long hold-off.",
                 sb.quadrant_hits[0], sb.quadrant_hits[1],
                 sb.quadrant_hits[2], sb.quadrant_hits[3]);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
